[rtl/core/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the mismatch labeler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WMPL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define WMPL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define WMPL_ASSERT(lbl, prop, msg)
`define WMPL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/core/wmpl_pkg.sv]
// Types, constants and helper functions of the windowed mismatch parent labeler.
`default_nettype none
package wmpl_pkg;

    localparam int MAX_HALF     = 63;
    localparam int MAX_LEN      = 1048576;
    localparam int DEFAULT_HALF = 50;
    localparam int HALF_W       = 6;
    localparam int BASE_W       = 8;
    localparam int SUM_W        = $clog2(2 * MAX_HALF + 2);
    localparam int CNT_W        = $clog2(MAX_LEN + 1);

    typedef struct packed {
        logic [BASE_W-1:0] child_base;
        logic [BASE_W-1:0] parent_a_base;
        logic [BASE_W-1:0] parent_b_base;
        logic              last;
    } wmpl_in_t;

    typedef struct packed {
        logic             label;
        logic             base_mismatch;
        logic [CNT_W-1:0] position;
        logic [CNT_W-1:0] mismatch_total;
        logic [CNT_W-1:0] switch_total;
        logic             final_res;
    } wmpl_out_t;

    // One window position: mis_a and mis_b are the mismatch bits against A and B.
    typedef struct packed {
        logic valid;
        logic mis_b;
        logic mis_a;
    } wmpl_entry_t;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum_a;
        logic [SUM_W-1:0] sum_b;
        wmpl_entry_t      center;
        logic             final_res;
    } wmpl_emit_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v < CNT_W'(MAX_LEN)) ? v + CNT_W'(1) : CNT_W'(MAX_LEN);
    endfunction

    function automatic logic [HALF_W-1:0] eff_half(input logic [HALF_W-1:0] v);
        if (v == '0)
        begin
            return HALF_W'(DEFAULT_HALF);
        end
        else if (v > HALF_W'(MAX_HALF))
        begin
            return HALF_W'(MAX_HALF);
        end
        return v;
    endfunction

endpackage
`default_nettype wire

[rtl/core/wmpl_cell.sv]
// One cell of the window delay line: holds one position's mismatch pair.
`default_nettype none
module wmpl_cell (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  shift_en,
    input  wire                  clear,
    input  wire                  is_head,
    input  wmpl_pkg::wmpl_entry_t inject,
    input  wmpl_pkg::wmpl_entry_t from_up,
    output wmpl_pkg::wmpl_entry_t q
);
    import wmpl_pkg::*;

    wmpl_entry_t q_reg;
    wmpl_entry_t q_next;

    always_comb
    begin
        q_next = q_reg;
        if (clear)
        begin
            q_next = '0;
        end
        else if (shift_en)
        begin
            q_next = is_head ? inject : from_up;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

[rtl/core/wmpl_row.sv]
// A row of delay cells whose entry point is set by the half window width.
`default_nettype none
module wmpl_row (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      shift_en,
    input  wire                      clear,
    input  wire [wmpl_pkg::HALF_W-1:0] head,
    input  wmpl_pkg::wmpl_entry_t     inject,
    output wmpl_pkg::wmpl_entry_t     tail
);
    import wmpl_pkg::*;

    wmpl_entry_t cells [MAX_HALF];

    // New entries enter at cell head-1 and walk down toward cell 0, so the row
    // is exactly head cells long; cells above the head stay empty.
    for (genvar k = 0; k < MAX_HALF; k++)
    begin : g_cell
        wmpl_entry_t up;
        if (k == MAX_HALF - 1)
        begin : g_top
            assign up = '0;
        end
        else
        begin : g_mid
            assign up = cells[k+1];
        end

        wmpl_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .clear    (clear),
            .is_head  (head == HALF_W'(k + 1)),
            .inject   (inject),
            .from_up  (up),
            .q        (cells[k])
        );
    end

    assign tail = cells[0];

endmodule
`default_nettype wire

[rtl/core/wmpl_label.sv]
// Label decision and running totals for one window center per cycle.
`default_nettype none
module wmpl_label (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   clear,
    input  wmpl_pkg::wmpl_emit_t  emit,
    output logic                  res_wr,
    output wmpl_pkg::wmpl_out_t   res
);
    import wmpl_pkg::*;

    logic             prev_label_reg;
    logic             prev_label_next;
    logic [CNT_W-1:0] emitted_reg;
    logic [CNT_W-1:0] emitted_next;
    logic [CNT_W-1:0] mis_cnt_reg;
    logic [CNT_W-1:0] mis_cnt_next;
    logic [CNT_W-1:0] sw_cnt_reg;
    logic [CNT_W-1:0] sw_cnt_next;

    logic             lab;
    logic             bm;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] mis;
    logic [CNT_W-1:0] sw;

    always_comb
    begin
        // A tie keeps the label of the position before.
        lab = prev_label_reg;
        if (emit.sum_a < emit.sum_b)
        begin
            lab = 1'b0;
        end
        else if (emit.sum_b < emit.sum_a)
        begin
            lab = 1'b1;
        end
        bm  = lab ? emit.center.mis_b : emit.center.mis_a;
        pos = sat_inc(emitted_reg);
        mis = bm ? sat_inc(mis_cnt_reg) : mis_cnt_reg;
        sw  = ((emitted_reg != '0) && (lab != prev_label_reg)) ? sat_inc(sw_cnt_reg)
                                                                : sw_cnt_reg;

        res.label          = lab;
        res.base_mismatch  = bm;
        res.position       = pos;
        res.mismatch_total = mis;
        res.switch_total   = sw;
        res.final_res      = emit.final_res;
        res_wr             = emit.valid;

        prev_label_next = prev_label_reg;
        emitted_next    = emitted_reg;
        mis_cnt_next    = mis_cnt_reg;
        sw_cnt_next     = sw_cnt_reg;
        if (clear || (emit.valid && emit.final_res))
        begin
            prev_label_next = 1'b0;
            emitted_next    = '0;
            mis_cnt_next    = '0;
            sw_cnt_next     = '0;
        end
        else if (emit.valid)
        begin
            prev_label_next = lab;
            emitted_next    = pos;
            mis_cnt_next    = mis;
            sw_cnt_next     = sw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_label_reg <= 1'b0;
            emitted_reg    <= '0;
            mis_cnt_reg    <= '0;
            sw_cnt_reg     <= '0;
        end
        else
        begin
            prev_label_reg <= prev_label_next;
            emitted_reg    <= emitted_next;
            mis_cnt_reg    <= mis_cnt_next;
            sw_cnt_reg     <= sw_cnt_next;
        end
    end

endmodule
`default_nettype wire

[rtl/core/windowed_mismatch_parent_labeler.sv]
// Top level of the windowed mismatch parent labeler.
// The block takes one aligned position per clock while src_stall is low and labels each
// position with the parent (A or B) that has fewer child mismatches over a centered window
// of 2*half+1 positions, clipped at both sequence ends. Results lag the input by half items,
// then pass the emit register (shift, window sums) and the label stage (label, totals) into
// the result queue. After the item marked last the block flushes the delay line with half
// empty shifts, at most one result each, and holds src_stall high meanwhile; the next
// sequence may start in the cycle after that. A four-item result queue lets input keep
// flowing while a result waits to be taken. Writing cfg_wdata restarts the sequence state.
`default_nettype none
`include "assert_macros.svh"
module windowed_mismatch_parent_labeler (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        cfg_we,
    input  wire [wmpl_pkg::HALF_W-1:0] cfg_wdata,
    input  wire                        src_valid,
    output logic                       src_stall,
    input  wmpl_pkg::wmpl_in_t         src_data,
    output logic                       res_valid,
    input  wire                        res_stall,
    output wmpl_pkg::wmpl_out_t        res_data
);
    import wmpl_pkg::*;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 2);

    logic [HALF_W-1:0] h_reg;
    logic [HALF_W-1:0] h_next;
    logic              flushing_reg;
    logic              flushing_next;
    logic [HALF_W-1:0] flush_cnt_reg;
    logic [HALF_W-1:0] flush_cnt_next;
    logic [SUM_W-1:0]  sum_a_reg;
    logic [SUM_W-1:0]  sum_a_next;
    logic [SUM_W-1:0]  sum_b_reg;
    logic [SUM_W-1:0]  sum_b_next;
    wmpl_emit_t        emit_reg;
    wmpl_emit_t        emit_next;

    logic              advance;
    logic              src_take;
    logic              dummy_push;
    logic              last_dummy;
    logic              push;
    logic              seq_clear;
    wmpl_entry_t       new_entry;
    wmpl_entry_t       f_tail;
    wmpl_entry_t       center_q;
    wmpl_entry_t       g_tail;
    logic [SUM_W-1:0]  sum_a_calc;
    logic [SUM_W-1:0]  sum_b_calc;

    logic              res_wr;
    wmpl_out_t         res_new;
    wmpl_out_t         fifo_mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FCNT_W-1:0] fifo_count_reg;
    logic [FCNT_W-1:0] fifo_count_next;
    logic              pop;

    // The queue must hold whatever is in flight, so new work starts only while the
    // queued results plus the one in the label stage leave a free slot.
    assign advance    = (fifo_count_reg + FCNT_W'(emit_reg.valid)) < FCNT_W'(FIFO_DEPTH);
    assign src_stall  = !advance || flushing_reg;
    assign src_take   = src_valid && !src_stall;
    assign dummy_push = flushing_reg && advance;
    assign last_dummy = dummy_push && (flush_cnt_reg == HALF_W'(1));
    assign push       = src_take || dummy_push;
    assign seq_clear  = last_dummy || cfg_we;

    always_comb
    begin
        new_entry = '0;
        if (src_take)
        begin
            new_entry.valid = 1'b1;
            new_entry.mis_a = (src_data.child_base != src_data.parent_a_base);
            new_entry.mis_b = (src_data.child_base != src_data.parent_b_base);
        end
    end

    // Front row: the half newest positions. Then the window center, then the back row.
    wmpl_row u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (push),
        .clear    (seq_clear),
        .head     (h_reg),
        .inject   (new_entry),
        .tail     (f_tail)
    );

    wmpl_cell u_center (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (push),
        .clear    (seq_clear),
        .is_head  (1'b1),
        .inject   (f_tail),
        .from_up  (f_tail),
        .q        (center_q)
    );

    wmpl_row u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (push),
        .clear    (seq_clear),
        .head     (h_reg),
        .inject   (center_q),
        .tail     (g_tail)
    );

    // The back row's tail is the position that leaves the window on this shift.
    assign sum_a_calc = sum_a_reg + SUM_W'(new_entry.mis_a)
                        - SUM_W'(g_tail.valid & g_tail.mis_a);
    assign sum_b_calc = sum_b_reg + SUM_W'(new_entry.mis_b)
                        - SUM_W'(g_tail.valid & g_tail.mis_b);

    always_comb
    begin
        h_next         = h_reg;
        flushing_next  = flushing_reg;
        flush_cnt_next = flush_cnt_reg;
        sum_a_next     = sum_a_reg;
        sum_b_next     = sum_b_reg;

        emit_next           = '0;
        emit_next.sum_a     = sum_a_calc;
        emit_next.sum_b     = sum_b_calc;
        emit_next.center    = f_tail;
        emit_next.final_res = last_dummy;
        emit_next.valid     = push && f_tail.valid && !cfg_we;

        if (cfg_we)
        begin
            h_next        = eff_half(cfg_wdata);
            flushing_next = 1'b0;
        end
        else if (src_take && src_data.last)
        begin
            flushing_next  = 1'b1;
            flush_cnt_next = h_reg;
        end
        else if (dummy_push)
        begin
            flush_cnt_next = flush_cnt_reg - HALF_W'(1);
            if (last_dummy)
            begin
                flushing_next = 1'b0;
            end
        end

        if (seq_clear)
        begin
            sum_a_next = '0;
            sum_b_next = '0;
        end
        else if (push)
        begin
            sum_a_next = sum_a_calc;
            sum_b_next = sum_b_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg         <= HALF_W'(DEFAULT_HALF);
            flushing_reg  <= 1'b0;
            flush_cnt_reg <= '0;
            sum_a_reg     <= '0;
            sum_b_reg     <= '0;
            emit_reg      <= '0;
        end
        else
        begin
            h_reg         <= h_next;
            flushing_reg  <= flushing_next;
            flush_cnt_reg <= flush_cnt_next;
            sum_a_reg     <= sum_a_next;
            sum_b_reg     <= sum_b_next;
            emit_reg      <= emit_next;
        end
    end

    wmpl_label u_label (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (cfg_we),
        .emit   (emit_reg),
        .res_wr (res_wr),
        .res    (res_new)
    );

    assign res_valid = (fifo_count_reg != '0);
    assign res_data  = fifo_mem_reg[rd_ptr_reg];
    assign pop       = res_valid && !res_stall;

    always_comb
    begin
        wr_ptr_next     = res_wr ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next     = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fifo_count_next = fifo_count_reg + FCNT_W'(res_wr) - FCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            fifo_count_reg <= fifo_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_wr)
        begin
            fifo_mem_reg[wr_ptr_reg] <= res_new;
        end
    end

    `WMPL_ASSERT(a_fifo_bound, fifo_count_reg <= FCNT_W'(FIFO_DEPTH), "result queue overflow")
    `WMPL_ASSERT(a_sum_a_bound, sum_a_reg <= ({h_reg, 1'b1}), "window sum A exceeds window")
    `WMPL_ASSERT(a_sum_b_bound, sum_b_reg <= ({h_reg, 1'b1}), "window sum B exceeds window")
    `WMPL_ASSERT(a_last_starts_flush, (src_take && src_data.last) |=> flushing_reg, "no flush")
    `WMPL_ASSERT(a_flush_final, last_dummy |=> (emit_reg.valid && emit_reg.final_res), "no final")

endmodule
`default_nettype wire
